>>> hdl/sine_wave_pixel_displacer_assert.svh
// Assertion macros for the sine-wave pixel displacer.
`ifndef SINE_WAVE_PIXEL_DISPLACER_ASSERT_SVH
`define SINE_WAVE_PIXEL_DISPLACER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SWPD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swpd: assertion failed");

// Check cons a fixed number of cycles after ante.
`define SWPD_ASSERT_LATER(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("swpd: delayed assertion failed");

`endif

>>> hdl/swpd_pkg.sv
package swpd_pkg;

   localparam int unsigned MAX_DIM_DEF        = 4096;
   localparam int unsigned SINE_FRAC_BITS_DEF = 16;

   localparam int unsigned COORD_IN_W  = 12;
   localparam int unsigned COORD_OUT_W = 13;
   localparam int unsigned DIM_W       = 13;
   localparam int unsigned PIXEL_W     = 24;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned ADDR_W      = 26;
   localparam int unsigned AMP_W       = 8;
   localparam int unsigned WAVE_W      = 7;
   localparam int unsigned STEP_W      = 8;

   // angle arithmetic
   localparam int unsigned PROD_W        = COORD_IN_W + STEP_W;
   localparam int unsigned RECIP_SHIFT   = 28;
   localparam int unsigned FULL_TURN     = 360;
   localparam int unsigned HALF_TURN     = 180;
   localparam int unsigned QUARTER       = 90;
   localparam int unsigned THREE_QUARTER = 270;
   localparam int unsigned RECIP         = (1 << RECIP_SHIFT) / FULL_TURN;
   localparam int unsigned RECIP_PROD_W  = 2 * PROD_W;
   localparam int unsigned QUOT_W        = 12;
   localparam int unsigned REM_W         = 10;
   localparam int unsigned ANGLE_W       = 9;
   localparam int unsigned DEG_W         = 7;
   localparam int unsigned ROM_DEPTH     = QUARTER + 1;

   // placement arithmetic
   localparam int unsigned SHIFT_W      = AMP_W + 2;
   localparam int unsigned WRAP_W       = 15;
   localparam int unsigned OUT_SPAN_W   = DIM_W + 1;
   localparam int unsigned ROW_PROD_W   = COORD_OUT_W + OUT_SPAN_W;
   localparam int unsigned SUM_W        = ROW_PROD_W + 1;
   localparam int unsigned ADDR_WIDE_W  = SUM_W + 2;
   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

   localparam int unsigned LATENCY = 8;

   // register file
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_SIZE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_DEPTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVELENGTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd6;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef struct packed {
      logic [COORD_IN_W-1:0] col;
      logic [COORD_IN_W-1:0] row;
      logic [PIXEL_W-1:0]    pix;
   } item_type;

   typedef struct packed {
      logic              direction;
      logic              keep_size;
      logic              pixel_depth;
      logic [AMP_W-1:0]  amplitude;
      logic [STEP_W-1:0] step;
      logic [DIM_W-1:0]  image_width;
      logic [DIM_W-1:0]  image_height;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      item_type         item;
      logic [DEG_W-1:0] deg;
      logic             neg;
   } angle_type;

   typedef struct packed {
      logic             valid;
      item_type         item;
      logic [AMP_W-1:0] mag;
      logic             neg;
   } shift_type;

   typedef struct packed {
      logic                   valid;
      logic [COORD_OUT_W-1:0] dest_column;
      logic [COORD_OUT_W-1:0] dest_row;
      logic [ADDR_W-1:0]      dest_byte_address;
      logic [PIXEL_W-1:0]     pixel_out;
      logic                   wrap_overflow;
   } result_type;

   // Two Q30 multiplies of the Taylor recurrence.
   function automatic longint unsigned sine_next(input longint unsigned t,
                                                 input longint unsigned x);
      return (((t * x) >> 30) * x) >> 30;
   endfunction

   // sin(deg) for deg in 0..90, frac fraction bits, rounded half up.
   function automatic longint unsigned sine_rom_entry(input int unsigned deg,
                                                      input int unsigned frac);
      longint unsigned x;
      longint unsigned t;
      longint          sum;
      x   = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
      t   = x;
      sum = longint'(x);
      t   = sine_next(t, x) / 64'd6;
      sum = sum - longint'(t);
      t   = sine_next(t, x) / 64'd20;
      sum = sum + longint'(t);
      t   = sine_next(t, x) / 64'd42;
      sum = sum - longint'(t);
      t   = sine_next(t, x) / 64'd72;
      sum = sum + longint'(t);
      t   = sine_next(t, x) / 64'd110;
      sum = sum - longint'(t);
      t   = sine_next(t, x) / 64'd156;
      sum = sum + longint'(t);
      t   = sine_next(t, x) / 64'd210;
      sum = sum - longint'(t);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      return (64'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
   endfunction

endpackage

>>> hdl/swpd_angle.sv
module swpd_angle
   import swpd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   input  item_type  in_item,
   output angle_type angle_out
);

   logic                  v1_ff, v1_in;
   item_type              item1_ff, item1_in;
   logic [PROD_W-1:0]     prod1_ff, prod1_in;
   logic                  v2_ff, v2_in;
   item_type              item2_ff, item2_in;
   logic [PROD_W-1:0]     prod2_ff, prod2_in;
   logic [QUOT_W-1:0]     quot2_ff, quot2_in;
   angle_type             angle_ff, angle_in;

   logic [COORD_IN_W-1:0]   index_w;
   logic [RECIP_PROD_W-1:0] recip_prod;
   logic [PROD_W-1:0]       rem_full;
   logic [REM_W-1:0]        rem_raw;
   logic [ANGLE_W-1:0]      angle_w;

   // index times degrees per step
   always_comb begin
      index_w  = cfg.direction ? in_item.col : in_item.row;
      v1_in    = in_valid;
      item1_in = in_item;
      prod1_in = PROD_W'(index_w) * PROD_W'(cfg.step);
   end

   // quotient by 360 through the reciprocal, may be one short
   always_comb begin
      recip_prod = RECIP_PROD_W'(prod1_ff) * RECIP_PROD_W'(RECIP);
      v2_in      = v1_ff;
      item2_in   = item1_ff;
      prod2_in   = prod1_ff;
      quot2_in   = QUOT_W'(recip_prod >> RECIP_SHIFT);
   end

   // remainder, correct once, fold into the first quadrant
   always_comb begin
      rem_full = prod2_ff - PROD_W'(quot2_ff) * PROD_W'(FULL_TURN);
      rem_raw  = rem_full[REM_W-1:0];
      if (rem_raw >= REM_W'(FULL_TURN)) begin
         angle_w = ANGLE_W'(rem_raw - REM_W'(FULL_TURN));
      end else begin
         angle_w = ANGLE_W'(rem_raw);
      end
      angle_in.valid = v2_ff;
      angle_in.item  = item2_ff;
      if (angle_w <= ANGLE_W'(QUARTER)) begin
         angle_in.deg = DEG_W'(angle_w);
         angle_in.neg = 1'b0;
      end else if (angle_w <= ANGLE_W'(HALF_TURN)) begin
         angle_in.deg = DEG_W'(ANGLE_W'(HALF_TURN) - angle_w);
         angle_in.neg = 1'b0;
      end else if (angle_w <= ANGLE_W'(THREE_QUARTER)) begin
         angle_in.deg = DEG_W'(angle_w - ANGLE_W'(HALF_TURN));
         angle_in.neg = 1'b1;
      end else begin
         angle_in.deg = DEG_W'(ANGLE_W'(FULL_TURN) - angle_w);
         angle_in.neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         angle_ff.valid <= 1'b0;
      end else begin
         v1_ff          <= v1_in;
         v2_ff          <= v2_in;
         angle_ff.valid <= angle_in.valid;
      end
      item1_ff      <= item1_in;
      prod1_ff      <= prod1_in;
      item2_ff      <= item2_in;
      prod2_ff      <= prod2_in;
      quot2_ff      <= quot2_in;
      angle_ff.item <= angle_in.item;
      angle_ff.deg  <= angle_in.deg;
      angle_ff.neg  <= angle_in.neg;
   end

   assign angle_out = angle_ff;

endmodule

>>> hdl/swpd_shift.sv
module swpd_shift
   import swpd_pkg::*;
#(
   parameter int unsigned SINE_FRAC_BITS = SINE_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  angle_type angle_in,
   output shift_type shift_out
);

   localparam int unsigned ROM_W = SINE_FRAC_BITS + 1;
   localparam int unsigned MUL_W = ROM_W + AMP_W;

   logic [ROM_W-1:0] rom_tbl [0:ROM_DEPTH-1];

   logic             v4_ff, v4_in;
   item_type         item4_ff, item4_in;
   logic [ROM_W-1:0] rom4_ff, rom4_in;
   logic             neg4_ff, neg4_in;
   shift_type        shift_ff, shift_in;

   logic [MUL_W-1:0] mag_prod;

   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
      assign rom_tbl[g] = ROM_W'(sine_rom_entry(g, SINE_FRAC_BITS));
   end

   // sine lookup
   always_comb begin
      v4_in    = angle_in.valid;
      item4_in = angle_in.item;
      neg4_in  = angle_in.neg;
      if (angle_in.deg <= DEG_W'(QUARTER)) begin
         rom4_in = rom_tbl[angle_in.deg];
      end else begin
         rom4_in = '0;
      end
   end

   // scale by the amplitude, keep the integer part
   always_comb begin
      mag_prod       = MUL_W'(rom4_ff) * MUL_W'(cfg.amplitude);
      shift_in.valid = v4_ff;
      shift_in.item  = item4_ff;
      shift_in.mag   = AMP_W'(mag_prod >> SINE_FRAC_BITS);
      shift_in.neg   = neg4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff          <= 1'b0;
         shift_ff.valid <= 1'b0;
      end else begin
         v4_ff          <= v4_in;
         shift_ff.valid <= shift_in.valid;
      end
      item4_ff      <= item4_in;
      rom4_ff       <= rom4_in;
      neg4_ff       <= neg4_in;
      shift_ff.item <= shift_in.item;
      shift_ff.mag  <= shift_in.mag;
      shift_ff.neg  <= shift_in.neg;
   end

   assign shift_out = shift_ff;

endmodule

>>> hdl/swpd_place.sv
module swpd_place
   import swpd_pkg::*;
#(
   parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  shift_type  shift_in,
   output result_type result_out
);

   logic                   v6_ff, v6_in;
   logic [PIXEL_W-1:0]     pix6_ff, pix6_in;
   logic [COORD_OUT_W-1:0] col6_ff, col6_in;
   logic [COORD_OUT_W-1:0] row6_ff, row6_in;
   logic [OUT_SPAN_W-1:0]  span6_ff, span6_in;
   logic                   ovf6_ff, ovf6_in;

   logic                   v7_ff, v7_in;
   logic [PIXEL_W-1:0]     pix7_ff, pix7_in;
   logic [COORD_OUT_W-1:0] col7_ff, col7_in;
   logic [COORD_OUT_W-1:0] row7_ff, row7_in;
   logic [ROW_PROD_W-1:0]  prod7_ff, prod7_in;
   logic                   ovf7_ff, ovf7_in;

   result_type             result_ff, result_in;

   logic [DIM_W-1:0]          w_eff;
   logic [DIM_W-1:0]          h_eff;
   logic [DIM_W-1:0]          span_w;
   logic [COORD_IN_W-1:0]     moving;
   logic signed [SHIFT_W-1:0] shift_s;
   logic signed [WRAP_W-1:0]  span_s;
   logic signed [WRAP_W-1:0]  wrap_raw;
   logic signed [WRAP_W-1:0]  wrap_w;
   logic [COORD_OUT_W-1:0]    extend_w;
   logic [COORD_OUT_W-1:0]    moved;
   logic                      ovf_w;
   logic [SUM_W-1:0]          sum_w;
   logic [ADDR_WIDE_W-1:0]    wide_w;

   // moving coordinate, wrap or pad, output span
   always_comb begin
      w_eff = (32'(cfg.image_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.image_width;
      h_eff = (32'(cfg.image_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.image_height;
      span_w  = cfg.direction ? h_eff : w_eff;
      moving  = cfg.direction ? shift_in.item.row : shift_in.item.col;
      shift_s = shift_in.neg ? -$signed(SHIFT_W'(shift_in.mag))
                             : $signed(SHIFT_W'(shift_in.mag));
      span_s   = $signed(WRAP_W'(span_w));
      wrap_raw = $signed(WRAP_W'(moving)) + WRAP_W'(shift_s);
      if (wrap_raw < 0) begin
         wrap_w = wrap_raw + span_s;
      end else if (wrap_raw >= span_s) begin
         wrap_w = wrap_raw - span_s;
      end else begin
         wrap_w = wrap_raw;
      end
      extend_w = COORD_OUT_W'(moving) + COORD_OUT_W'(cfg.amplitude)
                 + COORD_OUT_W'(shift_s);
      ovf_w = cfg.keep_size && ((wrap_w < 0) || (wrap_w >= span_s));
      moved = cfg.keep_size ? COORD_OUT_W'(wrap_w) : extend_w;

      v6_in   = shift_in.valid;
      pix6_in = shift_in.item.pix;
      ovf6_in = ovf_w;
      if (!cfg.direction && !cfg.keep_size) begin
         span6_in = OUT_SPAN_W'(w_eff) + OUT_SPAN_W'({cfg.amplitude, 1'b0});
      end else begin
         span6_in = OUT_SPAN_W'(w_eff);
      end
      if (ovf_w) begin
         col6_in = '0;
         row6_in = '0;
      end else if (cfg.direction) begin
         col6_in = COORD_OUT_W'(shift_in.item.col);
         row6_in = moved;
      end else begin
         col6_in = moved;
         row6_in = COORD_OUT_W'(shift_in.item.row);
      end
   end

   // row times span
   always_comb begin
      v7_in    = v6_ff;
      pix7_in  = pix6_ff;
      col7_in  = col6_ff;
      row7_in  = row6_ff;
      ovf7_in  = ovf6_ff;
      prod7_in = ROW_PROD_W'(row6_ff) * ROW_PROD_W'(span6_ff);
   end

   // add column, scale by bytes per pixel, saturate
   always_comb begin
      sum_w = SUM_W'(prod7_ff) + SUM_W'(col7_ff);
      if (cfg.pixel_depth) begin
         wide_w = ADDR_WIDE_W'(sum_w) + (ADDR_WIDE_W'(sum_w) << 1);
      end else begin
         wide_w = ADDR_WIDE_W'(sum_w);
      end
      result_in.valid       = v7_ff;
      result_in.dest_column = col7_ff;
      result_in.dest_row    = row7_ff;
      if (wide_w > ADDR_WIDE_W'(ADDR_MAX)) begin
         result_in.dest_byte_address = ADDR_MAX;
      end else begin
         result_in.dest_byte_address = wide_w[ADDR_W-1:0];
      end
      if (cfg.pixel_depth) begin
         result_in.pixel_out = pix7_ff;
      end else begin
         result_in.pixel_out = PIXEL_W'(pix7_ff[BYTE_W-1:0]);
      end
      result_in.wrap_overflow = ovf7_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff           <= 1'b0;
         v7_ff           <= 1'b0;
         result_ff.valid <= 1'b0;
      end else begin
         v6_ff           <= v6_in;
         v7_ff           <= v7_in;
         result_ff.valid <= result_in.valid;
      end
      pix6_ff  <= pix6_in;
      col6_ff  <= col6_in;
      row6_ff  <= row6_in;
      span6_ff <= span6_in;
      ovf6_ff  <= ovf6_in;
      pix7_ff  <= pix7_in;
      col7_ff  <= col7_in;
      row7_ff  <= row7_in;
      prod7_ff <= prod7_in;
      ovf7_ff  <= ovf7_in;
      result_ff.dest_column       <= result_in.dest_column;
      result_ff.dest_row          <= result_in.dest_row;
      result_ff.dest_byte_address <= result_in.dest_byte_address;
      result_ff.pixel_out         <= result_in.pixel_out;
      result_ff.wrap_overflow     <= result_in.wrap_overflow;
   end

   assign result_out = result_ff;

endmodule

>>> hdl/sine_wave_pixel_displacer.sv
// Sine-wave pixel displacer: one pixel transaction in per clock, one result out per transaction.
// Each result passes through the pipeline registers and is driven on the rsp_ ports for a single cycle.
// Throughput: one transaction per cycle, set by the eight-register pipeline (angle, sine, place).
// The receiver cannot stall; results are never held back.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults;
// busy is high only while reset is high.
`include "sine_wave_pixel_displacer_assert.svh"

module sine_wave_pixel_displacer
   import swpd_pkg::*;
#(
   parameter int unsigned MAX_DIM        = MAX_DIM_DEF,
   parameter int unsigned SINE_FRAC_BITS = SINE_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel transaction in
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_IN_W-1:0]  req_src_column,
   input  logic [COORD_IN_W-1:0]  req_src_row,
   input  logic [PIXEL_W-1:0]     req_pixel_value,
   // result out
   output logic                   rsp_valid,
   output logic [COORD_OUT_W-1:0] rsp_dest_column,
   output logic [COORD_OUT_W-1:0] rsp_dest_row,
   output logic [ADDR_W-1:0]      rsp_dest_byte_address,
   output logic [PIXEL_W-1:0]     rsp_pixel_out,
   output logic                   rsp_wrap_overflow,
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Wavelength is never kept as such: a write stores 180 div wavelength,
   // looked up in a constant table (zero counts as one).
   logic [STEP_W-1:0] step_tbl [0:(2**WAVE_W)-1];

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid;
   item_type   in_item;
   angle_type  angle_w;
   shift_type  shift_w;
   result_type result_w;

   for (genvar g = 0; g < (2**WAVE_W); g++) begin : g_step
      localparam int unsigned WlEff = (g == 0) ? 1 : g;
      assign step_tbl[g] = STEP_W'(HALF_TURN / WlEff);
   end

   // Register file. The user must write only while no transaction is in flight, as
   // every stage reads the live registers; the block itself does not enforce it.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DIRECTION:    cfg_in.direction    = csr_wdata[0];
            CSR_KEEP_SIZE:    cfg_in.keep_size    = csr_wdata[0];
            CSR_PIXEL_DEPTH:  cfg_in.pixel_depth  = csr_wdata[0];
            CSR_AMPLITUDE:    cfg_in.amplitude    = csr_wdata[AMP_W-1:0];
            CSR_WAVELENGTH:   cfg_in.step         = step_tbl[csr_wdata[WAVE_W-1:0]];
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[DIM_W-1:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction    <= 1'b1;
         cfg_ff.keep_size    <= 1'b0;
         cfg_ff.pixel_depth  <= 1'b0;
         cfg_ff.amplitude    <= '0;
         cfg_ff.step         <= STEP_W'(HALF_TURN);
         cfg_ff.image_width  <= DIM_W'(1);
         cfg_ff.image_height <= DIM_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Take a transaction whenever start is high outside reset.
   assign busy        = reset;
   assign in_valid    = start & ~busy;
   assign in_item.col = req_src_column;
   assign in_item.row = req_src_row;
   assign in_item.pix = req_pixel_value;

   // Stages 1 to 3: index times step, reduce modulo 360, fold to a quadrant.
   swpd_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (in_valid),
      .in_item   (in_item),
      .angle_out (angle_w)
   );

   // Stages 4 and 5: sine table, scale by amplitude.
   swpd_shift #(
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_shift (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .angle_in  (angle_w),
      .shift_out (shift_w)
   );

   // Stages 6 to 8: move the coordinate, wrap or pad, form the byte address.
   swpd_place #(
      .MAX_DIM (MAX_DIM)
   ) u_place (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .shift_in   (shift_w),
      .result_out (result_w)
   );

   // Drive the result ports straight from the last pipeline register.
   assign rsp_valid             = result_w.valid;
   assign rsp_dest_column       = result_w.dest_column;
   assign rsp_dest_row          = result_w.dest_row;
   assign rsp_dest_byte_address = result_w.dest_byte_address;
   assign rsp_pixel_out         = result_w.pixel_out;
   assign rsp_wrap_overflow     = result_w.wrap_overflow;

   // Every transaction produces a result, and no result appears without one.
   `SWPD_ASSERT_LATER(a_result_follows, clock, reset, start && !busy, LATENCY, rsp_valid)
   `SWPD_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy, LATENCY))
   // An unwrappable shift clears the destination fields.
   `SWPD_ASSERT_IMP(a_overflow_zero, clock, reset, rsp_valid && rsp_wrap_overflow, rsp_dest_column == '0 && rsp_dest_row == '0 && rsp_dest_byte_address == '0)

endmodule

>>> dv/sine_wave_pixel_displacer_test.sv
module sine_wave_pixel_displacer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import swpd_pkg::*;

   // Give up once this many cycles pass with neither a pixel nor a result moving.
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned RANDOM_SETUPS = 17;
   localparam int unsigned PIXELS_PER_SETUP = 100;

   // Local copy of the register file, kept in step with every write we make.
   typedef struct packed {
      logic              direction;
      logic              keep_size;
      logic              pixel_depth;
      logic [AMP_W-1:0]  amplitude;
      logic [WAVE_W-1:0] wavelength;
      logic [DIM_W-1:0]  image_width;
      logic [DIM_W-1:0]  image_height;
   } warp_cfg_type;

   typedef struct packed {
      logic [COORD_IN_W-1:0] col;
      logic [COORD_IN_W-1:0] row;
      logic [PIXEL_W-1:0]    pix;
   } pixel_req_type;

   typedef struct packed {
      logic [COORD_OUT_W-1:0] dest_column;
      logic [COORD_OUT_W-1:0] dest_row;
      logic [ADDR_W-1:0]      dest_byte_address;
      logic [PIXEL_W-1:0]     pixel_out;
      logic                   wrap_overflow;
   } placement_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [COORD_IN_W-1:0]  req_src_column = '0;
   logic [COORD_IN_W-1:0]  req_src_row = '0;
   logic [PIXEL_W-1:0]     req_pixel_value = '0;
   logic                   rsp_valid;
   logic [COORD_OUT_W-1:0] rsp_dest_column;
   logic [COORD_OUT_W-1:0] rsp_dest_row;
   logic [ADDR_W-1:0]      rsp_dest_byte_address;
   logic [PIXEL_W-1:0]     rsp_pixel_out;
   logic                   rsp_wrap_overflow;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // sin(0..90 degrees) in unsigned Q1.16, filled once at time zero
   longint unsigned sine_q16 [0:QUARTER];

   warp_cfg_type   live_cfg;
   pixel_req_type  pixels_to_send [$];
   placement_type  placements_due [$];
   pixel_req_type  in_flight;
   int unsigned pixels_owed = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;

   sine_wave_pixel_displacer DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_src_column        (req_src_column),
      .req_src_row           (req_src_row),
      .req_pixel_value       (req_pixel_value),
      .rsp_valid             (rsp_valid),
      .rsp_dest_column       (rsp_dest_column),
      .rsp_dest_row          (rsp_dest_row),
      .rsp_dest_byte_address (rsp_dest_byte_address),
      .rsp_pixel_out         (rsp_pixel_out),
      .rsp_wrap_overflow     (rsp_wrap_overflow),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Taylor series of sin to x^15/15! in Q30, rounded half up to Q1.16.
   function automatic longint unsigned taylor_sine(input int unsigned deg);
      longint unsigned x;
      longint unsigned term;
      longint          acc;
      x    = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
      term = x;
      acc  = longint'(x);
      for (longint unsigned k = 1; k <= 7; k++) begin
         term = (term * x) >> 30;
         term = ((term * x) >> 30) / ((2 * k) * (2 * k + 1));
         if (k[0]) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > (64'sd1 <<< 30)) begin
         acc = 64'sd1 <<< 30;
      end
      return (64'(acc) + (64'd1 << (29 - SINE_FRAC_BITS_DEF))) >> (30 - SINE_FRAC_BITS_DEF);
   endfunction

   // Signed displacement for one index: fold the angle into the first quadrant,
   // scale by the amplitude and truncate toward zero.
   function automatic longint wave_offset(input int unsigned index, input warp_cfg_type c);
      int unsigned     wl;
      int unsigned     ang;
      int unsigned     deg;
      logic            neg;
      longint unsigned mag;
      wl  = (c.wavelength == 0) ? 1 : c.wavelength;   // zero wavelength acts as one
      ang = (index * (HALF_TURN / wl)) % FULL_TURN;
      neg = (ang > HALF_TURN);
      if (ang <= QUARTER) begin
         deg = ang;
      end else if (ang <= HALF_TURN) begin
         deg = HALF_TURN - ang;
      end else if (ang <= THREE_QUARTER) begin
         deg = ang - HALF_TURN;
      end else begin
         deg = FULL_TURN - ang;
      end
      mag = (sine_q16[deg] * c.amplitude) >> SINE_FRAC_BITS_DEF;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   // Where a source pixel lands in the warped picture under the given settings.
   function automatic placement_type place_pixel(input pixel_req_type p, input warp_cfg_type c);
      longint        col;
      longint        row;
      longint        w;
      longint        h;
      longint        amp;
      longint        out_w;
      longint        shift;
      longint        addr;
      logic          ovf;
      placement_type r;
      col   = longint'(p.col);
      row   = longint'(p.row);
      // clip oversized pictures to the largest supported dimension
      w     = longint'((c.image_width > MAX_DIM_DEF) ? MAX_DIM_DEF : c.image_width);
      h     = longint'((c.image_height > MAX_DIM_DEF) ? MAX_DIM_DEF : c.image_height);
      amp   = longint'(c.amplitude);
      out_w = w;
      ovf   = 1'b0;
      if (c.direction) begin
         shift = wave_offset(p.col, c);
         if (c.keep_size) begin
            // wrap once; a zero span or a shift past a whole span still lands outside
            row = row + shift;
            if (row < 0) begin
               row = row + h;
            end else if (row >= h) begin
               row = row - h;
            end
            ovf = (row < 0 || row >= h);
         end else begin
            row = row + amp + shift;
         end
      end else begin
         shift = wave_offset(p.row, c);
         if (c.keep_size) begin
            col = col + shift;
            if (col < 0) begin
               col = col + w;
            end else if (col >= w) begin
               col = col - w;
            end
            ovf = (col < 0 || col >= w);
         end else begin
            col   = col + amp + shift;
            out_w = w + 2 * amp;
         end
      end
      if (ovf) begin
         col  = 0;
         row  = 0;
         addr = 0;
      end else begin
         addr = (row * out_w + col) * (c.pixel_depth ? 3 : 1);
         if (addr > longint'(ADDR_MAX)) begin
            addr = longint'(ADDR_MAX);
         end
         if (addr < 0) begin
            addr = 0;
         end
      end
      r.dest_column       = COORD_OUT_W'(col);
      r.dest_row          = COORD_OUT_W'(row);
      r.dest_byte_address = ADDR_W'(addr);
      r.pixel_out         = c.pixel_depth ? p.pix : {{(PIXEL_W - BYTE_W){1'b0}}, p.pix[BYTE_W-1:0]};
      r.wrap_overflow     = ovf;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Settings drawn with a lean towards the extremes of every register.
   function automatic warp_cfg_type random_setup();
      warp_cfg_type c;
      c.direction   = 1'($urandom_range(1));
      c.keep_size   = 1'($urandom_range(1));
      c.pixel_depth = 1'($urandom_range(1));
      case ($urandom_range(3))
         0: c.amplitude = '0;
         1: c.amplitude = '1;
         default: c.amplitude = AMP_W'($urandom_range(255));
      endcase
      case ($urandom_range(5))
         0: c.wavelength = 7'd1;
         1: c.wavelength = 7'd100;
         2: c.wavelength = 7'd0;
         default: c.wavelength = WAVE_W'($urandom_range(1, 100));
      endcase
      case ($urandom_range(5))
         0: c.image_width = 13'd1;
         1: c.image_width = 13'd4096;
         2: c.image_width = DIM_W'($urandom_range(4097, 8191));
         default: c.image_width = DIM_W'($urandom_range(1, 600));
      endcase
      case ($urandom_range(5))
         0: c.image_height = 13'd1;
         1: c.image_height = 13'd4096;
         2: c.image_height = DIM_W'($urandom_range(4097, 8191));
         default: c.image_height = DIM_W'($urandom_range(1, 600));
      endcase
      return c;
   endfunction

   // Mostly pixels inside the picture, so that hold mode wraps for real; the rest
   // anywhere in the coordinate range.
   function automatic pixel_req_type random_pixel(input warp_cfg_type c);
      pixel_req_type p;
      int unsigned   w;
      int unsigned   h;
      w     = (c.image_width > MAX_DIM_DEF) ? MAX_DIM_DEF : c.image_width;
      h     = (c.image_height > MAX_DIM_DEF) ? MAX_DIM_DEF : c.image_height;
      p.col = COORD_IN_W'((w == 0 || $urandom_range(4) == 0) ? $urandom_range(4095)
                                                             : $urandom_range(w - 1));
      p.row = COORD_IN_W'((h == 0 || $urandom_range(4) == 0) ? $urandom_range(4095)
                                                             : $urandom_range(h - 1));
      p.pix = PIXEL_W'($urandom());
      return p;
   endfunction

   task automatic queue_pixel(input pixel_req_type p);
      pixels_to_send.push_back(p);
      pixels_owed++;
   endtask

   task automatic send_pixel(input logic [COORD_IN_W-1:0] col, input logic [COORD_IN_W-1:0] row,
                             input logic [PIXEL_W-1:0] pix);
      queue_pixel('{col, row, pix});
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Write the whole register file; only ever called with the pipeline empty.
   task automatic load_setup(input warp_cfg_type c);
      write_reg(CSR_DIRECTION, CSR_DATA_W'(c.direction));
      write_reg(CSR_KEEP_SIZE, CSR_DATA_W'(c.keep_size));
      write_reg(CSR_PIXEL_DEPTH, CSR_DATA_W'(c.pixel_depth));
      write_reg(CSR_AMPLITUDE, CSR_DATA_W'(c.amplitude));
      write_reg(CSR_WAVELENGTH, CSR_DATA_W'(c.wavelength));
      write_reg(CSR_IMAGE_WIDTH, c.image_width);
      write_reg(CSR_IMAGE_HEIGHT, c.image_height);
      @(posedge clock);
      csr_we   <= 1'b0;
      live_cfg = c;
   endtask

   // Hold until every queued pixel has gone in and every placement has come back.
   task automatic wait_idle();
      while (pixels_owed != 0 || placements_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Driver: predict each transaction as it is taken, then offer the next one,
   // idling at random for the current share of cycles.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            placements_due.push_back(place_pixel(in_flight, live_cfg));
            pixels_owed--;
         end
         // hold the offer while busy, otherwise advance or drop start
         if (!start || !busy) begin
            if (pixels_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               in_flight = pixels_to_send.pop_front();
               start           <= 1'b1;
               req_src_column  <= in_flight.col;
               req_src_row     <= in_flight.row;
               req_pixel_value <= in_flight.pix;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is matched against the oldest placement due.
   always @(posedge clock) begin
      placement_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (placements_due.size() == 0) begin
            $error("result with no transaction outstanding");
            mismatches++;
         end else begin
            want = placements_due.pop_front();
            compare_field("dest_column", want.dest_column, rsp_dest_column);
            compare_field("dest_row", want.dest_row, rsp_dest_row);
            compare_field("dest_byte_address", want.dest_byte_address, rsp_dest_byte_address);
            compare_field("pixel_out", want.pixel_out, rsp_pixel_out);
            compare_field("wrap_overflow", want.wrap_overflow, rsp_wrap_overflow);
         end
      end
   end

   // Watchdog: count cycles with no transaction and no result.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sine_wave_pixel_displacer_test: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int unsigned  idle_modes [3];
      warp_cfg_type cfg;
      idle_modes = '{0, 73, 33};
      for (int unsigned d = 0; d <= QUARTER; d++) begin
         sine_q16[d] = taylor_sine(d);
      end
      // register values after reset
      live_cfg = '{1'b1, 1'b0, 1'b0, 8'd0, 7'd1, 13'd1, 13'd1};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: field extremes straight out of reset.
      send_pixel(12'd0, 12'd0, 24'h000000);
      send_pixel(12'd4095, 12'd4095, 24'hFFFFFF);
      wait_idle();

      // Horizontal extend, three-byte pixels, full amplitude, quarter turn per row:
      // the far corner stays below the address limit.
      load_setup('{1'b0, 1'b0, 1'b1, 8'd255, 7'd2, 13'd4096, 13'd4096});
      send_pixel(12'd4095, 12'd4095, 24'hFFFFFF);
      send_pixel(12'd0, 12'd1, 24'h123456);
      send_pixel(12'd0, 12'd3, 24'hA5A5A5);
      wait_idle();

      // Vertical hold: wrap below and above, both picture edges, and a source row
      // outside the picture that still overflows after one wrap.
      load_setup('{1'b1, 1'b1, 1'b0, 8'd200, 7'd2, 13'd8, 13'd300});
      send_pixel(12'd1, 12'd150, 24'h0000C3);
      send_pixel(12'd3, 12'd100, 24'hFFFF3C);
      send_pixel(12'd1, 12'd99, 24'h000001);
      send_pixel(12'd3, 12'd200, 24'h000080);
      send_pixel(12'd1, 12'd100, 24'h00007F);
      send_pixel(12'd1, 12'd4095, 24'h5A5A5A);
      wait_idle();

      // Vertical hold with a shift beyond a whole picture span, either way.
      load_setup('{1'b1, 1'b1, 1'b0, 8'd200, 7'd2, 13'd8, 13'd100});
      send_pixel(12'd1, 12'd0, 24'h0000FF);
      send_pixel(12'd3, 12'd0, 24'h000055);
      wait_idle();

      // Horizontal hold on an oversized picture, clipped to the largest size.
      load_setup('{1'b0, 1'b1, 1'b1, 8'd255, 7'd2, 13'd8191, 13'd8191});
      send_pixel(12'd0, 12'd1, 24'h010203);
      send_pixel(12'd4095, 12'd1, 24'hFEDCBA);
      send_pixel(12'd10, 12'd3, 24'h00FF00);
      send_pixel(12'd0, 12'd2, 24'h800000);
      wait_idle();

      // Zero wavelength and a zero-width picture: every hold placement overflows.
      load_setup('{1'b0, 1'b1, 1'b0, 8'd7, 7'd0, 13'd0, 13'd5});
      send_pixel(12'd0, 12'd0, 24'h000011);
      send_pixel(12'd4095, 12'd7, 24'h0000EE);
      wait_idle();

      // Vertical extend at one degree per column.
      load_setup('{1'b1, 1'b0, 1'b1, 8'd100, 7'd100, 13'd4096, 13'd16});
      send_pixel(12'd90, 12'd5, 24'h0F0F0F);
      send_pixel(12'd270, 12'd15, 24'hF0F0F0);
      send_pixel(12'd45, 12'd0, 24'h333333);
      send_pixel(12'd4095, 12'd4095, 24'hCCCCCC);
      wait_idle();

      // Random settings, each with a stream of random pixels and its own idle share.
      for (int unsigned s = 0; s < RANDOM_SETUPS; s++) begin
         cfg = random_setup();
         load_setup(cfg);
         sender_idle_pct = idle_modes[s % 3];
         repeat (PIXELS_PER_SETUP) begin
            queue_pixel(random_pixel(cfg));
         end
         wait_idle();
      end

      // drain: let any stray result show up before the verdict
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatches == 0 && placements_due.size() == 0) begin
         $display("sine_wave_pixel_displacer_test: done, clean");
      end else begin
         $display("sine_wave_pixel_displacer_test: done, errors");
      end
      $finish;
   end

endmodule
